### hdl/dfmrw_pkg.sv
// Shared types, register codes and pan helpers for the dual FM write remapper.
`timescale 1ns / 1ps
package dfmrw_pkg;

   // Chip configuration modes
   typedef enum logic [1:0] {
      MODE_SINGLE = 2'd0,
      MODE_OPL3   = 2'd1,
      MODE_GOLD   = 2'd2,
      MODE_DUAL   = 2'd3
   } chip_mode_type;

   // Register indexes with special handling
   localparam logic [8:0] REG_NULL       = 9'h0FF;
   localparam logic [8:0] REG_WAVE_EN_LO = 9'h001;
   localparam logic [8:0] REG_WAVE_EN_HI = 9'h101;
   localparam logic [8:0] REG_TIMER1_HI  = 9'h102;
   localparam logic [8:0] REG_TIMER_CTL_HI = 9'h104;
   localparam logic [8:0] REG_KBD_SPLIT_HI = 9'h108;
   localparam logic [8:0] REG_RHYTHM_LO  = 9'h0BD;
   localparam logic [7:0] REG_RHYTHM_LOW8 = 8'hBD;
   localparam logic [7:0] REG_CHAN7_CTRL = 8'hC6;
   localparam logic [7:0] REG_CHAN8_CTRL = 8'hC7;
   localparam logic [7:0] REG_CHAN9_CTRL = 8'hC8;

   // One queued command: optional pan flush, optional copy, then the main write
   typedef struct packed {
      logic       flush;
      logic [7:0] shadow0;
      logic [7:0] shadow1;
      logic [7:0] shadow2;
      logic       copy;
      logic [7:0] copy_index;
      logic [7:0] copy_value;
      logic [8:0] main_index;
      logic [7:0] main_value;
   } cmd_type;

   // Pan bits: bit 4 = left OR NOT right, bit 5 = right
   function automatic logic [7:0] pan_bits(input logic left_on, input logic right_on);
      pan_bits = {2'b00, right_on, left_on | ~right_on, 4'b0000};
   endfunction

   function automatic logic [7:0] apply_pan(input logic [7:0] value,
                                            input logic left_on, input logic right_on);
      apply_pan = (value & ~8'h30) | pan_bits(left_on, right_on);
   endfunction

   // Channel 7-9 and operator 13-18 register ranges of one set
   function automatic logic in_rhythm_range(input logic [7:0] r);
      in_rhythm_range = (r >= 8'hA6 && r <= 8'hA8) || (r >= 8'hB6 && r <= 8'hB8) ||
                        (r >= 8'hC6 && r <= 8'hC8) || (r >= 8'h30 && r <= 8'h36) ||
                        (r >= 8'h50 && r <= 8'h56) || (r >= 8'h70 && r <= 8'h76) ||
                        (r >= 8'h90 && r <= 8'h96) || (r >= 8'hF0 && r <= 8'hF6);
   endfunction

endpackage

### hdl/dfmrw_front.sv
// Front end: mode register, item classification, rhythm and shadow state.
`timescale 1ns / 1ps
module dfmrw_front import dfmrw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_write_data,
   input  logic       req_push,
   input  logic       req_full,
   input  logic [8:0] req_reg_index,
   input  logic [7:0] req_reg_value,
   output logic       cmd_push,
   output cmd_type    cmd_data
);

   chip_mode_type mode_ff;
   logic          rhythm_left_ff, rhythm_left_in;
   logic          rhythm_right_ff, rhythm_right_in;
   logic [7:0]    shadow0_ff, shadow0_in;
   logic [7:0]    shadow1_ff, shadow1_in;
   logic [7:0]    shadow2_ff, shadow2_in;

   logic          accept;
   logic          drop;
   logic [8:0]    reg_v;
   logic [7:0]    val_v;
   logic          left_side;
   logic          side_now;
   logic          flush;
   logic          copy;
   logic [7:0]    copy_val;

   assign accept = req_push & ~req_full;

   // Classify the item and work out the next state
   always_comb begin
      drop            = (req_reg_index == REG_NULL);
      reg_v           = (mode_ff == MODE_SINGLE) ? {1'b0, req_reg_index[7:0]} : req_reg_index;
      val_v           = req_reg_value;
      rhythm_left_in  = rhythm_left_ff;
      rhythm_right_in = rhythm_right_ff;
      shadow0_in      = shadow0_ff;
      shadow1_in      = shadow1_ff;
      shadow2_in      = shadow2_ff;
      left_side       = 1'b0;
      side_now        = 1'b0;
      flush           = 1'b0;
      copy            = 1'b0;
      copy_val        = val_v;
      if (mode_ff == MODE_DUAL) begin
         if (reg_v == REG_WAVE_EN_LO || reg_v == REG_WAVE_EN_HI) begin
            drop = 1'b1;
         end
         // timer and keyboard split of set 2 go to set 1
         if ((reg_v >= REG_TIMER1_HI && reg_v <= REG_TIMER_CTL_HI) ||
             reg_v == REG_KBD_SPLIT_HI) begin
            reg_v = {1'b0, reg_v[7:0]};
         end
         // rhythm register of either side
         if (reg_v[7:0] == REG_RHYTHM_LOW8) begin
            left_side = ~reg_v[8];
            side_now  = left_side ? rhythm_left_ff : rhythm_right_ff;
            if (val_v[5] != side_now) begin
               flush = 1'b1;
               if (left_side) begin
                  rhythm_left_in = val_v[5];
               end else begin
                  rhythm_right_in = val_v[5];
               end
               shadow0_in = apply_pan(shadow0_ff, rhythm_left_in, rhythm_right_in);
               shadow1_in = apply_pan(shadow1_ff, rhythm_left_in, rhythm_right_in);
               shadow2_in = apply_pan(shadow2_ff, rhythm_left_in, rhythm_right_in);
            end
            val_v[5] = rhythm_left_in | rhythm_right_in;
            side_now = left_side ? rhythm_left_in : rhythm_right_in;
            if (val_v[4:0] != 5'd0 && !side_now) begin
               val_v[7:5] = 3'b111;
            end
            reg_v = REG_RHYTHM_LO;
         end
         // right-only rhythm: set 1 drum channels are muted
         if (!rhythm_left_in && rhythm_right_in && !reg_v[8] && in_rhythm_range(reg_v[7:0])) begin
            drop = 1'b1;
         end
         // right rhythm: set 2 drum channels are mirrored into set 1
         if (rhythm_right_in && reg_v[8] && in_rhythm_range(reg_v[7:0])) begin
            copy = 1'b1;
            if (reg_v[7:0] >= REG_CHAN7_CTRL && reg_v[7:0] <= REG_CHAN9_CTRL) begin
               copy_val = apply_pan(val_v, rhythm_left_in, rhythm_right_in);
            end else begin
               copy_val = val_v;
            end
         end
         // channel 7-9 control of set 1 gets pan bits and is shadowed
         if (!reg_v[8] && !drop &&
             reg_v[7:0] >= REG_CHAN7_CTRL && reg_v[7:0] <= REG_CHAN9_CTRL) begin
            val_v = apply_pan(val_v, rhythm_left_in, rhythm_right_in);
            case (reg_v[7:0])
               REG_CHAN7_CTRL: shadow0_in = val_v;
               REG_CHAN8_CTRL: shadow1_in = val_v;
               default:        shadow2_in = val_v;
            endcase
         end
      end
   end

   // Command to the back end
   always_comb begin
      cmd_push            = accept & ~drop;
      cmd_data.flush      = flush;
      cmd_data.shadow0    = shadow0_in;
      cmd_data.shadow1    = shadow1_in;
      cmd_data.shadow2    = shadow2_in;
      cmd_data.copy       = copy;
      cmd_data.copy_index = reg_v[7:0];
      cmd_data.copy_value = copy_val;
      cmd_data.main_index = reg_v;
      cmd_data.main_value = val_v;
   end

   // Mode register and tracked state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_SINGLE;
         rhythm_left_ff  <= 1'b0;
         rhythm_right_ff <= 1'b0;
         shadow0_ff      <= 8'd0;
         shadow1_ff      <= 8'd0;
         shadow2_ff      <= 8'd0;
      end else begin
         if (csr_write_enable) begin
            mode_ff <= chip_mode_type'(csr_write_data);
         end
         if (accept && !drop) begin
            rhythm_left_ff  <= rhythm_left_in;
            rhythm_right_ff <= rhythm_right_in;
            shadow0_ff      <= shadow0_in;
            shadow1_ff      <= shadow1_in;
            shadow2_ff      <= shadow2_in;
         end
      end
   end

endmodule

### hdl/dfmrw_queue.sv
// Command queue between the front and back ends.
`timescale 1ns / 1ps
module dfmrw_queue import dfmrw_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   cmd_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];
   assign do_push    = push & ~full;
   assign do_pop     = pop & head_valid;

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hdl/dfmrw_back.sv
// Back end: expands one command into chip writes, one per cycle while the result side keeps popping.
`timescale 1ns / 1ps
module dfmrw_back import dfmrw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_valid,
   input  cmd_type    cmd_data,
   output logic       cmd_pop,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [8:0] rsp_out_index,
   output logic [7:0] rsp_out_value,
   output logic       rsp_last
);

   localparam logic [1:0] STEP_FLUSH_MAIN = 2'd3;
   localparam logic [1:0] STEP_COPY_MAIN  = 2'd1;

   logic [1:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   logic [8:0] index_ff, index_in;
   logic [7:0] value_ff, value_in;
   logic       last_ff, last_in;
   logic       load;
   logic       is_main;

   assign load = cmd_valid & (~valid_ff | rsp_pop);

   // Pick the write for the current step
   always_comb begin
      if (cmd_data.flush) begin
         is_main = (step_ff == STEP_FLUSH_MAIN);
      end else if (cmd_data.copy) begin
         is_main = (step_ff == STEP_COPY_MAIN);
      end else begin
         is_main = 1'b1;
      end
      index_in = cmd_data.main_index;
      value_in = cmd_data.main_value;
      if (!is_main) begin
         if (cmd_data.flush) begin
            case (step_ff)
               2'd0: begin
                  index_in = {1'b0, REG_CHAN7_CTRL};
                  value_in = cmd_data.shadow0;
               end
               2'd1: begin
                  index_in = {1'b0, REG_CHAN8_CTRL};
                  value_in = cmd_data.shadow1;
               end
               default: begin
                  index_in = {1'b0, REG_CHAN9_CTRL};
                  value_in = cmd_data.shadow2;
               end
            endcase
         end else begin
            index_in = {1'b0, cmd_data.copy_index};
            value_in = cmd_data.copy_value;
         end
      end
      last_in  = is_main;
      cmd_pop  = load & is_main;
      step_in  = step_ff;
      valid_in = valid_ff;
      if (load) begin
         step_in  = is_main ? 2'd0 : step_ff + 2'd1;
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         index_ff <= index_in;
         value_ff <= value_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_empty     = ~valid_ff;
   assign rsp_out_index = index_ff;
   assign rsp_out_value = value_ff;
   assign rsp_last      = last_ff;

endmodule

### hdl/dual_fm_register_write_remapper_unit.sv
// Top level of the dual FM register write remapper.
`timescale 1ns / 1ps
// Turns each software register write (index, value) into zero to four chip
// writes, the final one flagged by rsp_last. The front end takes one item per
// clock while the command queue has room, updates the rhythm flags and the
// channel 7-9 control shadows at once and queues a command; the back end
// drains a command one chip write per clock through its output register
// while the result side keeps popping. An item that is not dropped produces
// one to four writes (four only when a rhythm flag change flushes the three
// shadows), and items with no result still take their turn at the input. With
// an empty queue the first result of an item passes the queue slot and then
// the back end output register before it is on the result ports.
// csr_write_data selects the chip mode; write it only while the block is
// idle. QUEUE_DEPTH sets how many commands may wait between the two halves.
module dual_fm_register_write_remapper_unit import dfmrw_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_write_data,
   input  logic       req_push,
   output logic       req_full,
   input  logic [8:0] req_reg_index,
   input  logic [7:0] req_reg_value,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [8:0] rsp_out_index,
   output logic [7:0] rsp_out_value,
   output logic       rsp_last
);

   logic    cmd_push;
   cmd_type cmd_in;
   logic    cmd_valid;
   cmd_type cmd_head;
   logic    cmd_pop;

   // Classification and state
   dfmrw_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_reg_index    (req_reg_index),
      .req_reg_value    (req_reg_value),
      .cmd_push         (cmd_push),
      .cmd_data         (cmd_in)
   );

   // Decoupling queue
   dfmrw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_data  (cmd_in),
      .full       (req_full),
      .pop        (cmd_pop),
      .head_valid (cmd_valid),
      .head_data  (cmd_head)
   );

   // Write sequencing
   dfmrw_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (cmd_valid),
      .cmd_data      (cmd_head),
      .cmd_pop       (cmd_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_index (rsp_out_index),
      .rsp_out_value (rsp_out_value),
      .rsp_last      (rsp_last)
   );

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the dual FM register write remapper.
`timescale 1ns / 1ps
module testbench;
   import dfmrw_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   // Register indexes used by the stimulus beyond the package set
   localparam logic [8:0] REG_TIMER2_HI   = 9'h103;
   localparam logic [8:0] REG_RHYTHM_HI   = 9'h1BD;
   localparam logic [8:0] REG_TOP         = 9'h1FF;
   localparam logic [8:0] REG_TEST_LO     = 9'h000;
   localparam logic [8:0] REG_MULT_HI     = 9'h120;
   localparam logic [8:0] REG_CH7_FNUM_LO = 9'h0A6;
   localparam logic [8:0] REG_CH8_FNUM_HI = 9'h1A7;
   localparam logic [8:0] REG_CH9_CTRL_HI = 9'h1C8;
   localparam logic [8:0] REG_OP18_WAV_HI = 9'h1F6;

   // One chip write as seen on the result side
   typedef struct packed {
      logic [8:0] index;
      logic [7:0] value;
      logic       is_last;
   } chip_write_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write_enable = 1'b0;
   logic [1:0] csr_write_data = MODE_SINGLE;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [8:0] req_reg_index = '0;
   logic [7:0] req_reg_value = '0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [8:0] rsp_out_index;
   logic [7:0] rsp_out_value;
   logic       rsp_last;

   // Predictor state
   chip_mode_type cur_mode = MODE_SINGLE;
   logic          left_rhythm = 1'b0;
   logic          right_rhythm = 1'b0;
   logic [7:0]    ctrl_shadow [3] = '{8'h00, 8'h00, 8'h00};

   chip_write_type pending_writes [$];
   int             mismatch_count = 0;
   int             cycle_count = 0;
   logic           steady = 1'b0;

   dual_fm_register_write_remapper_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_reg_index    (req_reg_index),
      .req_reg_value    (req_reg_value),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_index    (rsp_out_index),
      .rsp_out_value    (rsp_out_value),
      .rsp_last         (rsp_last)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   // Pan bits of channels 7-9 from the current rhythm flags
   function automatic logic [7:0] with_pan(input logic [7:0] v);
      return {v[7:6], right_rhythm, left_rhythm | ~right_rhythm, v[3:0]};
   endfunction

   // Channel 7-9 and operator 13-18 slots of one register set
   function automatic logic is_drum_slot(input logic [7:0] r);
      case (r[7:4])
         4'h3, 4'h5, 4'h7, 4'h9, 4'hF: return r[3:0] <= 4'd6;
         4'hA, 4'hB, 4'hC:             return r[3:0] >= 4'd6 && r[3:0] <= 4'd8;
         default:                      return 1'b0;
      endcase
   endfunction

   function automatic logic is_chan_ctrl(input logic [7:0] r);
      return r >= REG_CHAN7_CTRL && r <= REG_CHAN9_CTRL;
   endfunction

   function automatic void add_write(input logic [8:0] idx, input logic [7:0] val,
                                     input logic is_last);
      chip_write_type w;
      w.index   = idx;
      w.value   = val;
      w.is_last = is_last;
      pending_writes.push_back(w);
   endfunction

   // Chip writes caused by one software register write
   function automatic void remap_write(input logic [8:0] idx_in, input logic [7:0] val_in);
      logic [8:0] r;
      logic [7:0] v;
      logic       want_on;
      logic       on_left;
      logic       side_on;
      r = idx_in;
      v = val_in;
      if (r == REG_NULL) return;
      if (cur_mode == MODE_SINGLE) r[8] = 1'b0;
      if (cur_mode == MODE_DUAL) begin
         if (r == REG_WAVE_EN_LO || r == REG_WAVE_EN_HI) return;
         // timer and keyboard-split registers go to set 1
         if (r >= REG_TIMER1_HI && r <= REG_TIMER_CTL_HI) r[8] = 1'b0;
         if (r == REG_KBD_SPLIT_HI) r[8] = 1'b0;
         // rhythm register of either side
         if (r[7:0] == REG_RHYTHM_LOW8) begin
            want_on = v[5];
            on_left = ~r[8];
            side_on = on_left ? left_rhythm : right_rhythm;
            if (want_on != side_on) begin
               if (on_left) left_rhythm = want_on;
               else right_rhythm = want_on;
               for (int i = 0; i < 3; i++) begin
                  ctrl_shadow[i] = with_pan(ctrl_shadow[i]);
                  add_write({1'b0, REG_CHAN7_CTRL + 8'(i)}, ctrl_shadow[i], 1'b0);
               end
            end
            v[5] = left_rhythm | right_rhythm;
            side_on = on_left ? left_rhythm : right_rhythm;
            if (v[4:0] != 5'd0 && !side_on) v[7:5] = 3'b111;
            r = REG_RHYTHM_LO;
         end
         // right side alone in rhythm mode owns the set-1 drum slots
         if (!left_rhythm && right_rhythm && !r[8] && is_drum_slot(r[7:0])) return;
         // right rhythm: set-2 drum slots are mirrored into set 1
         if (right_rhythm && r[8] && is_drum_slot(r[7:0]))
            add_write({1'b0, r[7:0]}, is_chan_ctrl(r[7:0]) ? with_pan(v) : v, 1'b0);
         if (!r[8] && is_chan_ctrl(r[7:0])) begin
            v = with_pan(v);
            ctrl_shadow[r[7:0] - REG_CHAN7_CTRL] = v;
         end
      end
      add_write(r, v, 1'b1);
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input int got, input int want_val);
      mismatch_count++;
      $display("%0t ns: %s mismatch, got %0h, want %0h", $time, what, got, want_val);
   endtask

   // Compare every popped write with the oldest prediction
   always @(posedge clock) begin : check_writes
      chip_write_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_writes.size() == 0) begin
            report_mismatch("unexpected write, index", rsp_out_index, 0);
         end else begin
            want = pending_writes.pop_front();
            if (rsp_out_index !== want.index)
               report_mismatch("out_index", rsp_out_index, want.index);
            if (rsp_out_value !== want.value)
               report_mismatch("out_value", rsp_out_value, want.value);
            if (rsp_last !== want.is_last)
               report_mismatch("last", rsp_last, want.is_last);
         end
      end
   end

   // Result side stalls about a quarter of the time unless steady
   always @(posedge clock) begin
      if (reset) rsp_pop <= 1'b0;
      else if (steady) rsp_pop <= 1'b1;
      else rsp_pop <= ($urandom_range(0, 99) >= 24);
   end

   // ---------------------------------------------------------------- stimulus

   // Send one item and predict its writes once it is taken
   task automatic send_item(input logic [8:0] idx, input logic [7:0] val);
      int gap;
      gap = 0;
      if (!steady && $urandom_range(0, 99) < 24) gap = $urandom_range(1, 4);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push      <= 1'b1;
      req_reg_index <= idx;
      req_reg_value <= val;
      @(posedge clock);
      while (req_full) @(posedge clock);
      remap_write(idx, val);
   endtask

   // Drain all predicted writes, then wait with no requests before returning
   task automatic wait_idle();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic set_chip_mode(input chip_mode_type m);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= m;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_mode = m;
   endtask

   // Index biased toward the registers with special handling
   function automatic logic [8:0] pick_index();
      logic [3:0] hi;
      logic [3:0] lo;
      case ($urandom_range(0, 7))
         0, 1: return 9'($urandom);
         2:    return {1'($urandom), REG_RHYTHM_LOW8};
         3, 4: begin
            if ($urandom_range(0, 1)) begin
               case ($urandom_range(0, 4))
                  0: hi = 4'h3;
                  1: hi = 4'h5;
                  2: hi = 4'h7;
                  3: hi = 4'h9;
                  default: hi = 4'hF;
               endcase
               lo = 4'($urandom_range(0, 6));
            end else begin
               hi = 4'($urandom_range(10, 12));
               lo = 4'($urandom_range(6, 8));
            end
            return {1'($urandom), hi, lo};
         end
         5: begin
            case ($urandom_range(0, 7))
               0: return REG_WAVE_EN_LO;
               1: return REG_WAVE_EN_HI;
               2: return REG_TIMER1_HI;
               3: return REG_TIMER2_HI;
               4: return REG_TIMER_CTL_HI;
               5: return REG_KBD_SPLIT_HI;
               6: return REG_NULL;
               default: return REG_TOP;
            endcase
         end
         6: return {1'($urandom), REG_CHAN7_CTRL + 8'($urandom_range(0, 2))};
         default: return {1'($urandom), 4'($urandom), 4'($urandom_range(5, 9))};
      endcase
   endfunction

   // Values often keep only bits 7-5, clearing the drum bits so flags toggle cleanly
   function automatic logic [7:0] pick_value();
      if ($urandom_range(0, 3) == 0) return 8'($urandom) & 8'hE0;
      return 8'($urandom);
   endfunction

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++) send_item(pick_index(), pick_value());
   endtask

   // Single chip: set 2 folds onto 8 bits, only the null index is dropped
   task automatic test_single_mode();
      set_chip_mode(MODE_SINGLE);
      send_item(REG_TEST_LO, 8'h00);
      send_item(REG_NULL, 8'hFF);
      send_item(REG_TOP, 8'hA5);
      send_item(REG_RHYTHM_HI, 8'hFF);
      send_item(REG_MULT_HI, 8'h5A);
      send_random(40);
   endtask

   // Three-operator chips pass the full 9-bit index
   task automatic test_three_op_modes();
      set_chip_mode(MODE_OPL3);
      send_item(REG_TOP, 8'h00);
      send_item(REG_NULL, 8'h11);
      send_item(REG_WAVE_EN_HI, 8'h01);
      send_random(30);
      set_chip_mode(MODE_GOLD);
      send_random(30);
   endtask

   // Dual mode: redirects, rhythm flag changes, drops and copies
   task automatic test_dual_directed();
      set_chip_mode(MODE_DUAL);
      send_item(REG_WAVE_EN_LO, 8'h20);
      send_item(REG_WAVE_EN_HI, 8'h20);
      send_item(REG_TIMER1_HI, 8'hFF);
      send_item(REG_TIMER2_HI, 8'h01);
      send_item(REG_TIMER_CTL_HI, 8'h80);
      send_item(REG_KBD_SPLIT_HI, 8'h40);
      send_item({1'b0, REG_CHAN7_CTRL}, 8'hFF);
      send_item({1'b0, REG_CHAN8_CTRL}, 8'h00);
      send_item(REG_RHYTHM_HI, 8'h20);       // right on, pan flush
      send_item(REG_CH7_FNUM_LO, 8'h11);     // dropped, right side alone
      send_item({1'b0, REG_CHAN7_CTRL}, 8'h0F);
      send_item(REG_CH8_FNUM_HI, 8'h22);     // copied to set 1
      send_item(REG_CH9_CTRL_HI, 8'hFF);     // copied with pan bits
      send_item(REG_RHYTHM_LO, 8'h3F);       // left on, pan flush
      send_item(REG_CH7_FNUM_LO, 8'h33);
      send_item(REG_RHYTHM_LO, 8'h01);       // left off, drum bits forced
      send_item(REG_RHYTHM_HI, 8'h00);       // right off
      send_item(REG_NULL, 8'h00);
      send_item(REG_OP18_WAV_HI, 8'h77);
      send_item(REG_RHYTHM_LO, 8'h00);
      send_item(REG_RHYTHM_HI, 8'hDF);
   endtask

   // Dual mode random traffic with a stretch of full throughput
   task automatic test_dual_random();
      send_random(100);
      steady = 1'b1;
      send_random(60);
      steady = 1'b0;
      send_random(100);
   endtask

   // Flags survive a mode change; return to single mode and back to dual
   task automatic test_mode_switch();
      set_chip_mode(MODE_SINGLE);
      send_random(20);
      set_chip_mode(MODE_DUAL);
      send_random(20);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_mode();
      test_three_op_modes();
      test_dual_directed();
      test_dual_random();
      test_mode_switch();
      wait_idle();
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### dual_fm_register_write_remapper_unit.f
hdl/dfmrw_pkg.sv
hdl/dfmrw_front.sv
hdl/dfmrw_queue.sv
hdl/dfmrw_back.sv
hdl/dual_fm_register_write_remapper_unit.sv
tb/sv/testbench.sv
